### rtl/mf3_pkg.sv
package mf3_pkg;

    localparam int MAX_SIZE   = 16;
    localparam int POS_W      = $clog2(MAX_SIZE);
    localparam int SIZE_W     = 5;
    localparam int PIX_W      = 8;
    localparam int SUM_W      = 12;
    localparam int CNT_W      = 4;
    localparam int RECIP_SH   = 16;
    localparam int RECIP_W    = RECIP_SH + 1;
    localparam int PROD_W     = SUM_W + RECIP_W;
    localparam int NKIND      = 4;

    localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);
    localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_SIZE);
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

    // result kinds in emission order
    localparam logic [1:0] KIND_UP_LEFT = 2'd0;
    localparam logic [1:0] KIND_UP      = 2'd1;
    localparam logic [1:0] KIND_LEFT    = 2'd2;
    localparam logic [1:0] KIND_HERE    = 2'd3;

    typedef logic [PIX_W-1:0] pix_t;

    // ceil(2^16 / cnt): exact quotient for sums below 2^12 and counts 1, 2, 3, 4, 6 and 9
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] r;
        unique case (cnt)
            4'd1:    r = RECIP_W'(65536);
            4'd2:    r = RECIP_W'(32768);
            4'd3:    r = RECIP_W'(21846);
            4'd4:    r = RECIP_W'(16384);
            4'd6:    r = RECIP_W'(10923);
            4'd9:    r = RECIP_W'(7282);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

### rtl/mean_filter_3x3_border_aware.sv
// 3x3 border-aware mean filter. Pixels of a square frame (side cfg_wr_data, clamped to
// 2..16) enter in raster order, one transaction per clock while s_tready is high. Each
// accepted pixel gives 0 to 4 results carrying row, column and the truncated mean of the
// in-frame neighbours; the master side delivers one result per clock while m_tready is
// high. A pixel with at most one result is taken every cycle unless stalled; a pixel with
// k > 1 results holds the slave side while the single result register serializes them
// (row ends, last-row pixels, and four results on the final pixel). The mean uses a
// reciprocal multiply, exact for all window sizes. Writing the frame size restarts the frame.
module mean_filter_3x3_border_aware (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [mf3_pkg::SIZE_W-1:0] cfg_wr_data,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [7:0] pixel
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [15:0]                m_tdata,   // [3:0] out_row, [7:4] out_col,
                                                  // [15:8] mean_value
    output logic                       m_tlast,   // last_in_run
    output logic                       m_tuser    // frame_done
);
    import mf3_pkg::*;

    logic [SIZE_W-1:0] frame_size_reg;
    logic [SIZE_W-1:0] n_eff;
    logic [POS_W-1:0]  row_reg, col_reg;

    pix_t              ls_up2_reg [MAX_SIZE];
    pix_t              ls_up1_reg [MAX_SIZE];
    pix_t              win_reg    [9];

    logic [NKIND-1:0]  pend_reg, pend_next;
    logic [POS_W-1:0]  job_r_reg, job_c_reg;

    logic              m_tvalid_reg;
    logic [15:0]       m_tdata_reg;
    logic              m_tlast_reg, m_tuser_reg;

    logic              accept, out_free, emit;
    logic              wrap;
    logic [POS_W-1:0]  r_cur, c_cur;
    logic [SIZE_W-1:0] r_ext, c_ext;
    logic              last_col, last_row;
    logic [NKIND-1:0]  pend_new;

    logic [1:0]        sel;
    logic [NKIND-1:0]  pend_left;
    logic              dr, dc;
    logic [2:0]        row_ok, col_ok;
    logic [SUM_W-1:0]  sum;
    logic [1:0]        rcnt, ccnt;
    logic [CNT_W-1:0]  cnt;
    logic [PROD_W-1:0] prod;
    pix_t              mean;
    logic [POS_W-1:0]  res_r, res_c;

    always_comb
    begin
        if (frame_size_reg < SIZE_MIN)
        begin
            n_eff = SIZE_MIN;
        end
        else if (frame_size_reg > SIZE_MAX)
        begin
            n_eff = SIZE_MAX;
        end
        else
        begin
            n_eff = frame_size_reg;
        end
    end

    // position of the incoming pixel
    always_comb
    begin
        wrap     = ({1'b0, row_reg} >= n_eff) || ({1'b0, col_reg} >= n_eff);
        r_cur    = wrap ? '0 : row_reg;
        c_cur    = wrap ? '0 : col_reg;
        r_ext    = {1'b0, r_cur};
        c_ext    = {1'b0, c_cur};
        last_col = (c_ext == n_eff - SIZE_W'(1));
        last_row = (r_ext == n_eff - SIZE_W'(1));
        pend_new[KIND_UP_LEFT] = (r_cur != '0) && (c_cur != '0);
        pend_new[KIND_UP]      = (r_cur != '0) && last_col;
        pend_new[KIND_LEFT]    = last_row && (c_cur != '0);
        pend_new[KIND_HERE]    = last_row && last_col;
    end

    // pick the next pending result, lowest kind first
    always_comb
    begin
        priority if (pend_reg[KIND_UP_LEFT])
        begin
            sel = KIND_UP_LEFT;
        end
        else if (pend_reg[KIND_UP])
        begin
            sel = KIND_UP;
        end
        else if (pend_reg[KIND_LEFT])
        begin
            sel = KIND_LEFT;
        end
        else
        begin
            sel = KIND_HERE;
        end
        pend_left      = pend_reg;
        pend_left[sel] = 1'b0;
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign emit     = (pend_reg != '0) && out_free;
    assign s_tready = (pend_reg == '0) || (emit && (pend_left == '0));
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        pend_next = pend_reg;
        if (emit)
        begin
            pend_next = pend_left;
        end
        if (accept)
        begin
            pend_next = pend_new;
        end
    end

    // window entry (kr,kc) holds pixel (r-2+kr, c-2+kc); mask out-of-frame and
    // out-of-neighborhood entries
    always_comb
    begin
        dr = (sel == KIND_LEFT) || (sel == KIND_HERE);
        dc = (sel == KIND_UP)   || (sel == KIND_HERE);
        for (int k = 0; k < 3; k++)
        begin
            row_ok[k] = (k >= int'(dr)) && ((k + int'(job_r_reg)) >= 2);
            col_ok[k] = (k >= int'(dc)) && ((k + int'(job_c_reg)) >= 2);
        end
        sum = '0;
        for (int kr = 0; kr < 3; kr++)
        begin
            for (int kc = 0; kc < 3; kc++)
            begin
                if (row_ok[kr] && col_ok[kc])
                begin
                    sum = sum + SUM_W'(win_reg[kr*3 + kc]);
                end
            end
        end
        rcnt  = 2'(row_ok[0]) + 2'(row_ok[1]) + 2'(row_ok[2]);
        ccnt  = 2'(col_ok[0]) + 2'(col_ok[1]) + 2'(col_ok[2]);
        cnt   = {2'b00, rcnt} * {2'b00, ccnt};
        prod  = PROD_W'(sum) * PROD_W'(recip(cnt));
        mean  = prod[RECIP_SH +: PIX_W];
        res_r = job_r_reg - POS_W'(!dr);
        res_c = job_c_reg - POS_W'(!dc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_size_reg <= SIZE_RESET;
            row_reg        <= '0;
            col_reg        <= '0;
            pend_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            pend_reg <= pend_next;
            if (cfg_wr_en)
            begin
                frame_size_reg <= cfg_wr_data;
                row_reg        <= '0;
                col_reg        <= '0;
            end
            else if (accept)
            begin
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : r_cur + POS_W'(1);
                end
                else
                begin
                    col_reg <= c_cur + POS_W'(1);
                    row_reg <= r_cur;
                end
            end
            if (accept)
            begin
                for (int kr = 0; kr < 3; kr++)
                begin
                    win_reg[kr*3 + 0] <= win_reg[kr*3 + 1];
                    win_reg[kr*3 + 1] <= win_reg[kr*3 + 2];
                end
                win_reg[2] <= ls_up2_reg[c_cur];
                win_reg[5] <= ls_up1_reg[c_cur];
                win_reg[8] <= s_tdata;
            end
            if (emit)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload: line store, job position, result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ls_up2_reg[c_cur] <= ls_up1_reg[c_cur];
            ls_up1_reg[c_cur] <= s_tdata;
            job_r_reg         <= r_cur;
            job_c_reg         <= c_cur;
        end
        if (emit)
        begin
            m_tdata_reg <= {mean, res_c, res_r};
            m_tlast_reg <= (pend_left == '0);
            m_tuser_reg <= (sel == KIND_HERE);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
